/* rtl/xxh64_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xxh64_pkg: shared constants, types and helpers for the XXH64 engine
// Primes, seed reset value, sequencer states and rotate/lane-start helpers.
// ---------------------------------------------------------------------------
package xxh64_pkg;

    localparam logic [63:0] PRIME1     = 64'd11400714785074694791;
    localparam logic [63:0] PRIME2     = 64'd14029467366897019727;
    localparam logic [63:0] PRIME3     = 64'd1609587929392839161;
    localparam logic [63:0] PRIME4     = 64'd9650029242287828579;
    localparam logic [63:0] PRIME5     = 64'd2870177450012600261;
    localparam logic [63:0] SEED_RESET = 64'h9E3779B185EBCA87;

    // four 64-bit lane accumulators
    typedef logic [3:0][63:0] lanes_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_MUL,
        ST_LR_A,
        ST_LR_B,
        ST_LR_C,
        ST_FIN,
        ST_CONV,
        ST_MG_A,
        ST_MG_B,
        ST_MG_C,
        ST_MG_D,
        ST_LEN,
        ST_PF_CHK,
        ST_PF_B,
        ST_PF_C,
        ST_PF_D,
        ST_TAIL4,
        ST_T4_B,
        ST_T4_C,
        ST_BY_CHK,
        ST_BY_B,
        ST_BY_C,
        ST_AV_A,
        ST_AV_B,
        ST_AV_C,
        ST_OUT
    } state_t;

    // rotate left by a fixed amount (1..63)
    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned s);
        logic [127:0] dbl;
        dbl = {v, v} << s;
        return dbl[127:64];
    endfunction

    // lane start values derived from a seed
    function automatic lanes_t lane_start(input logic [63:0] seed);
        lanes_t l;
        l[0] = seed + PRIME1 + PRIME2;
        l[1] = seed + PRIME2;
        l[2] = seed;
        l[3] = seed - PRIME1;
        return l;
    endfunction

endpackage

/* rtl/xxhash64_engine.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xxhash64_engine: streaming XXH64 over little-endian 64-bit words
// One shared 32x32 multiplier under a small sequencer does every multiply.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one request per 64-bit word. Only
//    the word with last set may carry fewer than 8 bytes (valid_bytes 0..8,
//    values above 8 count as 8). in_stall is high while the engine works.
//  - Output channel (out_valid / out_stall): one 64-bit hash per message,
//    held in an output register; the next word is taken while it waits.
//  - cfg_wr_en / cfg_wr_data load the seed and restart the message; write
//    only while the engine is idle.
//  - Every 64-bit multiply runs on the shared multiplier. A word that
//    goes to the pending buffer is only stored there. A word that
//    completes a 32-byte stripe runs 4 lane rounds. The finish merges
//    each lane after a stripe, folds each pending word, then the 4-byte
//    part and each single trailing byte, and ends with the avalanche.
//  - Reset loads the default seed and clears the message state.
//  - If the output register is still full when a hash is done, the engine
//    waits in its last state until the receiver takes the old hash.
// ---------------------------------------------------------------------------
module xxhash64_engine
    import xxh64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_value
);

    // control state
    state_t       state_reg, state_next;
    state_t       ret_reg, ret_next;
    logic [1:0]   phase_reg, phase_next;
    logic [1:0]   idx_reg, idx_next;
    logic [2:0]   pos_reg, pos_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         stripe_reg, stripe_next;
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  total_reg, total_next;
    logic [63:0]  seed_reg, seed_next;
    lanes_t       lane_reg, lane_next;

    // payload state
    logic [2:0][63:0] pend_reg, pend_next;
    logic [63:0]  word_reg, word_next;
    logic         full_reg, full_next;
    logic         last_reg, last_next;
    logic [2:0]   tlen_reg, tlen_next;
    logic [63:0]  h_reg, h_next;
    logic [63:0]  mul_a_reg, mul_a_next;
    logic [63:0]  mul_b_reg, mul_b_next;
    logic [63:0]  prod_reg, prod_next;
    logic [63:0]  hash_reg, hash_next;

    // datapath helpers
    logic         in_acc;
    logic [31:0]  mul_op_a, mul_op_b;
    logic [63:0]  pp;
    logic [63:0]  lane_sel;
    logic [63:0]  pend_sel;
    logic [63:0]  conv_term;
    logic [63:0]  tail_byte;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // shared multiplier: low 64 bits of a 64x64 product over three phases
    assign mul_op_a = (phase_reg == 2'd2) ? mul_a_reg[63:32] : mul_a_reg[31:0];
    assign mul_op_b = (phase_reg == 2'd1) ? mul_b_reg[63:32] : mul_b_reg[31:0];
    assign pp       = {32'd0, mul_op_a} * {32'd0, mul_op_b};

    always_comb
    begin
        if (phase_reg == 2'd0)
            prod_next = pp;
        else
            prod_next = prod_reg + {pp[31:0], 32'd0};
    end

    // operand selection by loop index
    assign lane_sel  = lane_reg[idx_reg];
    assign tail_byte = {56'd0, word_reg[{pos_reg, 3'b000} +: 8]};

    always_comb
    begin
        case (idx_reg)
            2'd0:    pend_sel = pend_reg[0];
            2'd1:    pend_sel = pend_reg[1];
            2'd2:    pend_sel = pend_reg[2];
            default: pend_sel = word_reg;
        endcase
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    conv_term = rotl64(lane_reg[0], 1);
            2'd1:    conv_term = rotl64(lane_reg[1], 7);
            2'd2:    conv_term = rotl64(lane_reg[2], 12);
            default: conv_term = rotl64(lane_reg[3], 18);
        endcase
    end

    // state and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            phase_reg     <= 2'd0;
            idx_reg       <= 2'd0;
            pos_reg       <= 3'd0;
            cnt_reg       <= 2'd0;
            stripe_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= 64'd0;
            seed_reg      <= SEED_RESET;
            lane_reg      <= lane_start(SEED_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            stripe_reg    <= stripe_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            seed_reg      <= seed_next;
            lane_reg      <= lane_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg  <= pend_next;
        word_reg  <= word_next;
        full_reg  <= full_next;
        last_reg  <= last_next;
        tlen_reg  <= tlen_next;
        h_reg     <= h_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        prod_reg  <= (state_reg == ST_MUL) ? prod_next : prod_reg;
        hash_reg  <= hash_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        stripe_next    = stripe_reg;
        out_valid_next = out_valid_reg;
        total_next     = total_reg;
        seed_next      = seed_reg;
        lane_next      = lane_reg;
        pend_next      = pend_reg;
        word_next      = word_reg;
        full_next      = full_reg;
        last_next      = last_reg;
        tlen_next      = tlen_reg;
        h_next         = h_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        hash_next      = hash_reg;

        // output register drains when taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    word_next  = data_word;
                    last_next  = last;
                    full_next  = !last || valid_bytes[3];
                    tlen_next  = (last && !valid_bytes[3]) ? valid_bytes[2:0] : 3'd0;
                    state_next = ST_ABSORB;
                end
            end

            // count bytes; fill pending buffer, start a stripe or start the finish
            ST_ABSORB:
            begin
                if (full_reg)
                begin
                    total_next = total_reg + 64'd8;
                    if (cnt_reg == 2'd3)
                    begin
                        idx_next   = 2'd0;
                        state_next = ST_LR_A;
                    end
                    else
                    begin
                        pend_next[cnt_reg] = word_reg;
                        cnt_next           = cnt_reg + 2'd1;
                        state_next         = last_reg ? ST_FIN : ST_IDLE;
                    end
                end
                else
                begin
                    total_next = total_reg + {61'd0, tlen_reg};
                    state_next = ST_FIN;
                end
            end

            // 64-bit multiply, one partial product per cycle
            ST_MUL:
            begin
                if (phase_reg == 2'd2)
                begin
                    phase_next = 2'd0;
                    state_next = ret_reg;
                end
                else
                    phase_next = phase_reg + 2'd1;
            end

            // lane round over the stripe
            ST_LR_A:
            begin
                mul_a_next = pend_sel;
                mul_b_next = PRIME2;
                ret_next   = ST_LR_B;
                state_next = ST_MUL;
            end
            ST_LR_B:
            begin
                mul_a_next = rotl64(lane_sel + prod_reg, 31);
                mul_b_next = PRIME1;
                ret_next   = ST_LR_C;
                state_next = ST_MUL;
            end
            ST_LR_C:
            begin
                lane_next[idx_reg] = prod_reg;
                if (idx_reg == 2'd3)
                begin
                    cnt_next    = 2'd0;
                    stripe_next = 1'b1;
                    idx_next    = 2'd0;
                    state_next  = last_reg ? ST_FIN : ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_LR_A;
                end
            end

            // start of finish: converge lanes or short-message start
            ST_FIN:
            begin
                idx_next = 2'd0;
                if (stripe_reg)
                begin
                    h_next     = 64'd0;
                    state_next = ST_CONV;
                end
                else
                begin
                    h_next     = seed_reg + PRIME5;
                    state_next = ST_LEN;
                end
            end
            ST_CONV:
            begin
                h_next = h_reg + conv_term;
                if (idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_MG_A;
                end
                else
                    idx_next = idx_reg + 2'd1;
            end

            // merge rounds
            ST_MG_A:
            begin
                mul_a_next = lane_sel;
                mul_b_next = PRIME2;
                ret_next   = ST_MG_B;
                state_next = ST_MUL;
            end
            ST_MG_B:
            begin
                mul_a_next = rotl64(prod_reg, 31);
                mul_b_next = PRIME1;
                ret_next   = ST_MG_C;
                state_next = ST_MUL;
            end
            ST_MG_C:
            begin
                mul_a_next = h_reg ^ prod_reg;
                mul_b_next = PRIME1;
                ret_next   = ST_MG_D;
                state_next = ST_MUL;
            end
            ST_MG_D:
            begin
                h_next = prod_reg + PRIME4;
                if (idx_reg == 2'd3)
                    state_next = ST_LEN;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_MG_A;
                end
            end

            ST_LEN:
            begin
                h_next     = h_reg + total_reg;
                idx_next   = 2'd0;
                state_next = ST_PF_CHK;
            end

            // fold pending full words
            ST_PF_CHK:
            begin
                if (idx_reg < cnt_reg)
                begin
                    mul_a_next = pend_sel;
                    mul_b_next = PRIME2;
                    ret_next   = ST_PF_B;
                    state_next = ST_MUL;
                end
                else
                    state_next = ST_TAIL4;
            end
            ST_PF_B:
            begin
                mul_a_next = rotl64(prod_reg, 31);
                mul_b_next = PRIME1;
                ret_next   = ST_PF_C;
                state_next = ST_MUL;
            end
            ST_PF_C:
            begin
                mul_a_next = rotl64(h_reg ^ prod_reg, 27);
                mul_b_next = PRIME1;
                ret_next   = ST_PF_D;
                state_next = ST_MUL;
            end
            ST_PF_D:
            begin
                h_next     = prod_reg + PRIME4;
                idx_next   = idx_reg + 2'd1;
                state_next = ST_PF_CHK;
            end

            // 4-byte part of the tail
            ST_TAIL4:
            begin
                pos_next = 3'd0;
                if (tlen_reg[2])
                begin
                    mul_a_next = {32'd0, word_reg[31:0]};
                    mul_b_next = PRIME1;
                    ret_next   = ST_T4_B;
                    state_next = ST_MUL;
                end
                else
                    state_next = ST_BY_CHK;
            end
            ST_T4_B:
            begin
                mul_a_next = rotl64(h_reg ^ prod_reg, 23);
                mul_b_next = PRIME2;
                ret_next   = ST_T4_C;
                state_next = ST_MUL;
            end
            ST_T4_C:
            begin
                h_next     = prod_reg + PRIME3;
                pos_next   = 3'd4;
                state_next = ST_BY_CHK;
            end

            // single trailing bytes
            ST_BY_CHK:
            begin
                if (pos_reg < tlen_reg)
                begin
                    mul_a_next = tail_byte;
                    mul_b_next = PRIME5;
                    ret_next   = ST_BY_B;
                    state_next = ST_MUL;
                end
                else
                    state_next = ST_AV_A;
            end
            ST_BY_B:
            begin
                mul_a_next = rotl64(h_reg ^ prod_reg, 11);
                mul_b_next = PRIME1;
                ret_next   = ST_BY_C;
                state_next = ST_MUL;
            end
            ST_BY_C:
            begin
                h_next     = prod_reg;
                pos_next   = pos_reg + 3'd1;
                state_next = ST_BY_CHK;
            end

            // avalanche
            ST_AV_A:
            begin
                mul_a_next = h_reg ^ (h_reg >> 33);
                mul_b_next = PRIME2;
                ret_next   = ST_AV_B;
                state_next = ST_MUL;
            end
            ST_AV_B:
            begin
                mul_a_next = prod_reg ^ (prod_reg >> 29);
                mul_b_next = PRIME3;
                ret_next   = ST_AV_C;
                state_next = ST_MUL;
            end
            ST_AV_C:
            begin
                h_next     = prod_reg ^ (prod_reg >> 32);
                state_next = ST_OUT;
            end

            // hand over the hash and restart the message
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    hash_next      = h_reg;
                    out_valid_next = 1'b1;
                    lane_next      = lane_start(seed_reg);
                    cnt_next       = 2'd0;
                    total_next     = 64'd0;
                    stripe_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // seed write reloads the lanes and drops the message
        if (cfg_wr_en)
        begin
            seed_next   = cfg_wr_data;
            lane_next   = lane_start(cfg_wr_data);
            cnt_next    = 2'd0;
            total_next  = 64'd0;
            stripe_next = 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    // multiplier phase only advances inside a multiply
    a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_MUL) |-> (phase_reg == 2'd0))
        else $error("multiplier phase active outside multiply");

    // an accepted word makes the engine busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("engine not busy after accepting a word");

    // a new hash appears only when the sequencer hands one over
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("output valid raised outside hand-over");

    // seed write clears the message state
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (cnt_reg == 2'd0 && total_reg == 64'd0 && !stripe_reg))
        else $error("message state not cleared by seed write");
`endif

endmodule
